[sv/egbr_pkg.sv]
// Shared types, codes and defaults for the Exp-Golomb bit reader.
package egbr_pkg;

	localparam int BUFFER_BITS_DEF = 64;
	localparam int MAX_PREFIX_DEF  = 31;

	localparam int VALUE_W     = 33;
	localparam int USED_W      = 6;
	localparam int LEFT_W      = 7;
	localparam int FIELD_MAX   = 32;
	localparam int WINDOW_W    = 64;
	localparam int BYTE_W      = 8;

	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_READ_U  = 2'd1,
		ACT_READ_UE = 2'd2,
		ACT_READ_SE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_SHORT  = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_PREFIX = 2'd3
	} status_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [USED_W-1:0]  bits_used;
		logic [LEFT_W-1:0]  bits_left;
		status_t            status;
	} result_t;

endpackage

[sv/egbr_core.sv]
// Combinational datapath: decodes one item against the bit buffer and gives the next buffer.
module egbr_core
	import egbr_pkg::*;
#(
	parameter int BUFFER_BITS = BUFFER_BITS_DEF,
	parameter int MAX_PREFIX  = MAX_PREFIX_DEF,
	localparam int HELD_W     = $clog2(BUFFER_BITS + 1)
) (
	input  logic [BUFFER_BITS-1:0] store,
	input  logic [HELD_W-1:0]      held,
	input  logic [1:0]             action,
	input  logic [7:0]             byte_in,
	input  logic [5:0]             read_width,
	output logic [BUFFER_BITS-1:0] next_store,
	output logic [HELD_W-1:0]      next_held,
	output result_t                result
);

	localparam int LZ_W  = $clog2(MAX_PREFIX + 2);
	localparam int CMP_W = (HELD_W > 8) ? HELD_W : 8;

	logic [MAX_PREFIX:0]      head;
	logic [LZ_W-1:0]          lz;
	logic [CMP_W-1:0]         code_len;
	logic [CMP_W-1:0]         held_x;
	logic [5:0]               width_sat;
	logic [6:0]               shift_n;
	logic [WINDOW_W-1:0]      window;
	logic [2*WINDOW_W-1:0]    shifted;
	logic [FIELD_MAX-1:0]     field;
	logic [FIELD_MAX-1:0]     k;
	logic                     prefix_long;
	logic                     code_short;
	logic [BUFFER_BITS-1:0]   insert;
	logic [5:0]               used;
	logic [VALUE_W-1:0]       value;
	status_t                  status;

	assign head   = store[BUFFER_BITS-1 -: MAX_PREFIX+1];
	assign window = store[BUFFER_BITS-1 -: WINDOW_W];
	assign held_x = CMP_W'(held);

	// Leading zeros over the prefix window; the highest set bit wins.
	always_comb begin
		lz = LZ_W'(MAX_PREFIX + 1);
		for (int i = 0; i <= MAX_PREFIX; i++) begin
			if (head[i]) begin
				lz = LZ_W'(MAX_PREFIX - i);
			end
		end
	end

	// The whole codeword sits at the head, and its prefix is zero, so the
	// top 2z+1 bits read as an integer equal the info field plus 2^z.
	assign code_len    = CMP_W'({lz, 1'b1});
	assign prefix_long = (lz == LZ_W'(MAX_PREFIX + 1)) && (held_x > CMP_W'(MAX_PREFIX));
	assign code_short  = code_len > held_x;
	assign width_sat   = (read_width > 6'(FIELD_MAX)) ? 6'(FIELD_MAX) : read_width;

	assign shift_n = (action_t'(action) == ACT_READ_U) ? 7'(width_sat) : code_len[6:0];
	assign shifted = {{WINDOW_W{1'b0}}, window} << shift_n;
	assign field   = shifted[WINDOW_W +: FIELD_MAX];
	assign k       = field - FIELD_MAX'(1);
	assign insert  = {byte_in, {(BUFFER_BITS-BYTE_W){1'b0}}} >> held;

	always_comb begin
		value      = '0;
		used       = '0;
		status     = STAT_OK;
		next_store = store;
		next_held  = held;
		case (action_t'(action))
			ACT_PUSH: begin
				if (CMP_W'(held) + CMP_W'(BYTE_W) > CMP_W'(BUFFER_BITS)) begin
					status = STAT_FULL;
				end else begin
					next_store = store | insert;
					next_held  = held + HELD_W'(BYTE_W);
				end
			end
			ACT_READ_U: begin
				if (CMP_W'(width_sat) > held_x) begin
					status = STAT_SHORT;
				end else begin
					value = {1'b0, field};
					used  = width_sat;
				end
			end
			ACT_READ_UE, ACT_READ_SE: begin
				if (prefix_long) begin
					status = STAT_PREFIX;
				end else if (code_short) begin
					status = STAT_SHORT;
				end else begin
					used = code_len[5:0];
					if (action_t'(action) == ACT_READ_UE) begin
						value = {1'b0, k};
					end else if (k[0]) begin
						value = ({1'b0, k} + VALUE_W'(1)) >> 1;
					end else begin
						value = VALUE_W'(0) - {2'b00, k[FIELD_MAX-1:1]};
					end
				end
			end
			default: begin
				status = STAT_OK;
			end
		endcase
		if (used != '0) begin
			next_store = store << used;
			next_held  = held - HELD_W'(used);
		end
	end

	assign result.value     = value;
	assign result.bits_used = used;
	assign result.bits_left = next_held[LEFT_W-1:0];
	assign result.status    = status;

endmodule

[sv/exp_golomb_bit_reader.sv]
// Top level of the MSB-first bitstream reader with ue(v) and se(v) decoding.
// Throughput: one item per cycle unless the result is stalled; every item, push or
// read, finishes in the single decode stage, whose leading-zero count and barrel
// shift set the cycle time. Each item and its result are registered.
// Reset (arst_n low, asynchronous): the bit buffer empties and both stages drop valid.
module exp_golomb_bit_reader
	import egbr_pkg::*;
#(
	parameter int BUFFER_BITS = BUFFER_BITS_DEF,
	parameter int MAX_PREFIX  = MAX_PREFIX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  byte_in,
	input  logic [5:0]  read_width,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [32:0] value,
	output logic [5:0]  bits_used,
	output logic [6:0]  bits_left,
	output logic [1:0]  status
);

	localparam int HELD_W = $clog2(BUFFER_BITS + 1);

	// Input stage: holds one item until the decode stage can hand its result on.
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [7:0]  byte_s1;
	logic [5:0]  width_s1;

	// Bit buffer: the head of the stream sits in the most significant bit,
	// and bits past the held count are always zero.
	logic [BUFFER_BITS-1:0] bit_store_q;
	logic [HELD_W-1:0]      bits_held_q;

	logic                   result_valid_q;
	result_t                result_q;

	logic [BUFFER_BITS-1:0] next_store;
	logic [HELD_W-1:0]      next_held;
	result_t                result_d;
	logic                   advance;
	logic                   load_s1;

	// The decode stage moves on whenever the result register is empty or its
	// current transfer completes, so a waiting result never blocks the input
	// by itself; only a full result register under stall does.
	assign advance    = valid_s1 && !(result_valid_q && result_stall);
	assign item_stall = valid_s1 && !advance;
	assign load_s1    = item_valid && !item_stall;

	egbr_core #(
		.BUFFER_BITS (BUFFER_BITS),
		.MAX_PREFIX  (MAX_PREFIX)
	) u_core (
		.store      (bit_store_q),
		.held       (bits_held_q),
		.action     (action_s1),
		.byte_in    (byte_s1),
		.read_width (width_s1),
		.next_store (next_store),
		.next_held  (next_held),
		.result     (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			bit_store_q    <= '0;
			bits_held_q    <= '0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			result_valid_q <= advance || (result_valid_q && result_stall);
			// The buffer is updated once per decoded item, in item order.
			if (advance) begin
				bit_store_q <= next_store;
				bits_held_q <= next_held;
			end
		end
	end

	// Payload registers carry no reset; valid bits qualify them.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			action_s1 <= action;
			byte_s1   <= byte_in;
			width_s1  <= read_width;
		end
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign value        = result_q.value;
	assign bits_used    = result_q.bits_used;
	assign bits_left    = result_q.bits_left;
	assign status       = result_q.status;

endmodule

[sv/egbr_checker.sv]
// Port-level assertions for the bit reader and the bind that attaches them.
module egbr_checker
	import egbr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic [1:0]  action,
	input logic [7:0]  byte_in,
	input logic [5:0]  read_width,
	input logic        result_valid,
	input logic        result_stall,
	input logic [32:0] value,
	input logic [5:0]  bits_used,
	input logic [6:0]  bits_left,
	input logic [1:0]  status
);

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(action)
			&& $stable(byte_in) && $stable(read_width))
		else $error("input item changed while stalled");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(value)
			&& $stable(bits_used) && $stable(bits_left) && $stable(status))
		else $error("result changed while stalled");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled with an empty result register");

	a_fail_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != STAT_OK |-> value == '0 && bits_used == '0)
		else $error("failed item reports a value or consumed bits");

	a_used_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bits_used != '0 |-> status == STAT_OK)
		else $error("bits consumed by a failed item");

endmodule

bind exp_golomb_bit_reader egbr_checker u_egbr_checker (.*);

[verif/testbench.sv]
// Self-checking testbench for the Exp-Golomb bitstream reader: directed table, then random traffic.
module testbench;
	import egbr_pkg::*;

	// Watchdog limit; a run that reaches it fails.
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1650;
	// After this many result transfers the receiver holds off for a long stretch.
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 200;
	localparam int REPORT_MAX  = 10;

	// One row of the directed table. When known is set, want holds the result that
	// can be read straight off the bit-level behavior; otherwise the predictor decides.
	typedef struct packed {
		action_t     act;
		logic [7:0]  byt;
		logic [5:0]  wid;
		logic        known;
		result_t     want;
	} stim_row_t;

	// A syntax element planned for the well-formed stream: how to read it and how
	// many bits it takes from the head of the buffer.
	typedef struct {
		action_t     act;
		logic [5:0]  wid;
		int          len;
	} planned_read_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  action = '0;
	logic [7:0]  byte_in = '0;
	logic [5:0]  read_width = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [32:0] value;
	logic [5:0]  bits_used;
	logic [6:0]  bits_left;
	logic [1:0]  status;

	// Shadow of the reader's state: stream bits left aligned, first bit in bit 63.
	logic [63:0] bit_window = '0;
	int          held_bits = 0;

	result_t       pending_fields[$];
	bit            plan_bits[$];
	planned_read_t plan_reads[$];

	int   items_sent = 0;
	int   mismatch_count = 0;
	int   cycle_count = 0;
	bit   tx_quiet = 1'b0;
	logic rx_holding = 1'b0;

	// The directed table walks the buffer through empty, all-zero, overlong prefix,
	// full, saturated width, the widest field, the longest ue code and a negative se.
	stim_row_t directed_rows [27] = '{
		'{ACT_READ_U,  8'h00, 6'd1,  1'b1, '{33'h0,          6'd0,  7'd0,  STAT_SHORT}},
		'{ACT_READ_U,  8'h00, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd0,  STAT_OK}},
		'{ACT_PUSH,    8'h00, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd8,  STAT_OK}},
		'{ACT_READ_UE, 8'h00, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd8,  STAT_SHORT}},
		'{ACT_PUSH,    8'h00, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd16, STAT_OK}},
		'{ACT_PUSH,    8'h00, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd24, STAT_OK}},
		'{ACT_PUSH,    8'h00, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd32, STAT_OK}},
		'{ACT_READ_UE, 8'h00, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd32, STAT_PREFIX}},
		'{ACT_PUSH,    8'hFF, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd40, STAT_OK}},
		'{ACT_PUSH,    8'hFF, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd48, STAT_OK}},
		'{ACT_PUSH,    8'hFF, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd56, STAT_OK}},
		'{ACT_PUSH,    8'hFF, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd64, STAT_OK}},
		'{ACT_PUSH,    8'hA5, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd64, STAT_FULL}},
		'{ACT_READ_U,  8'h00, 6'd63, 1'b1, '{33'h0,          6'd32, 7'd32, STAT_OK}},
		'{ACT_READ_U,  8'h00, 6'd32, 1'b1, '{33'h0_FFFF_FFFF, 6'd32, 7'd0,  STAT_OK}},
		'{ACT_PUSH,    8'h00, 6'd0,  1'b0, '0},
		'{ACT_PUSH,    8'h00, 6'd0,  1'b0, '0},
		'{ACT_PUSH,    8'h00, 6'd0,  1'b0, '0},
		'{ACT_PUSH,    8'h01, 6'd0,  1'b0, '0},
		'{ACT_PUSH,    8'hFF, 6'd0,  1'b0, '0},
		'{ACT_PUSH,    8'hFF, 6'd0,  1'b0, '0},
		'{ACT_PUSH,    8'hFF, 6'd0,  1'b0, '0},
		'{ACT_PUSH,    8'hFF, 6'd0,  1'b0, '0},
		'{ACT_READ_UE, 8'h00, 6'd0,  1'b1, '{33'h0_FFFF_FFFE, 6'd63, 7'd1,  STAT_OK}},
		'{ACT_PUSH,    8'h60, 6'd0,  1'b1, '{33'h0,          6'd0,  7'd9,  STAT_OK}},
		'{ACT_READ_SE, 8'h00, 6'd0,  1'b1, '{33'h0,          6'd1,  7'd8,  STAT_OK}},
		'{ACT_READ_SE, 8'h00, 6'd0,  1'b1, '{33'h1_FFFF_FFFF, 6'd3,  7'd5,  STAT_OK}}
	};

	exp_golomb_bit_reader DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.byte_in      (byte_in),
		.read_width   (read_width),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.bits_used    (bits_used),
		.bits_left    (bits_left),
		.status       (status)
	);

	always #6 clk = ~clk;

	// Predicts the result of one item and advances the shadow buffer. A failing
	// item leaves the buffer untouched and reports zero value and zero bits used.
	function automatic result_t decode_result(action_t act, logic [7:0] byt, logic [5:0] wid);
		result_t     r;
		int          n;
		int          z;
		logic [63:0] code;
		logic [32:0] k;
		r = '0;
		r.status = STAT_OK;
		n = 0;
		case (act)
			ACT_PUSH: begin
				if (held_bits + BYTE_W > BUFFER_BITS_DEF) begin
					r.status = STAT_FULL;
				end else begin
					bit_window[63 - held_bits -: 8] = byt;
					held_bits += BYTE_W;
				end
			end
			ACT_READ_U: begin
				// Widths above the field maximum saturate rather than fail.
				n = (wid > FIELD_MAX) ? FIELD_MAX : int'(wid);
				if (n > held_bits)
					r.status = STAT_SHORT;
				else
					r.value = 33'(bit_window >> (64 - n));
			end
			default: begin
				z = 0;
				while (z < held_bits && z <= MAX_PREFIX_DEF && bit_window[63 - z] == 1'b0)
					z++;
				// A run of zeros past the prefix limit is flagged even though more
				// bits might still arrive; a shorter code that is not yet complete
				// is only too few bits.
				if (z > MAX_PREFIX_DEF) begin
					r.status = STAT_PREFIX;
				end else if (2 * z + 1 > held_bits) begin
					r.status = STAT_SHORT;
				end else begin
					code = (bit_window << z) >> (63 - z);
					k = 33'(code - 64'd1);
					n = 2 * z + 1;
					if (act == ACT_READ_UE)
						r.value = k;
					else if (k[0])
						r.value = (k + 33'd1) >> 1;
					else
						r.value = 33'd0 - (k >> 1);
				end
			end
		endcase
		if (r.status == STAT_OK && n > 0) begin
			bit_window = bit_window << n;
			held_bits -= n;
		end
		r.bits_used = (r.status == STAT_OK) ? USED_W'(n) : '0;
		r.bits_left = LEFT_W'(held_bits);
		return r;
	endfunction

	// Presents one item and returns at the edge where its transfer happens. The
	// expectation is queued first; its result cannot show up before the transfer.
	task automatic send_item(action_t act, logic [7:0] byt, logic [5:0] wid,
			bit known = 1'b0, result_t typed = '0);
		result_t r;
		int      gap;
		r = decode_result(act, byt, wid);
		pending_fields.push_back(known ? typed : r);
		// While the receiver holds off, keep offering so the block backs up.
		gap = (tx_quiet || rx_holding) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		byte_in <= byt;
		read_width <= wid;
		do @(posedge clk); while (item_stall !== 1'b0);
		items_sent++;
	endtask

	// The sender stops offering until every outstanding result has been taken.
	task automatic wait_for_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_fields.size() != 0);
	endtask

	// Appends one random syntax element to the planned stream: a fixed-width field,
	// or a ue/se code whose prefix is mostly short but can reach the limit.
	task automatic plan_element();
		int            kind;
		int            n;
		int            z;
		int            i;
		planned_read_t rd;
		kind = $urandom_range(0, 2);
		if (kind == 0) begin
			n = $urandom_range(0, FIELD_MAX);
			for (i = 0; i < n; i++)
				plan_bits.push_back(1'($urandom));
			rd.act = ACT_READ_U;
			rd.len = n;
			rd.wid = (n == FIELD_MAX) ? 6'($urandom_range(FIELD_MAX, 63)) : 6'(n);
		end else begin
			z = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_PREFIX_DEF)
					: $urandom_range(0, 4);
			for (i = 0; i < z; i++)
				plan_bits.push_back(1'b0);
			plan_bits.push_back(1'b1);
			for (i = 0; i < z; i++)
				plan_bits.push_back(1'($urandom));
			rd.act = (kind == 1) ? ACT_READ_UE : ACT_READ_SE;
			rd.len = 2 * z + 1;
			rd.wid = 6'($urandom);
		end
		plan_reads.push_back(rd);
	endtask

	task automatic take_byte(output logic [7:0] b);
		int i;
		while (plan_bits.size() < BYTE_W)
			plan_element();
		for (i = 0; i < BYTE_W; i++)
			b = {b[6:0], plan_bits.pop_front()};
	endtask

	// Feeds the planned stream byte by byte and reads each element once its bits
	// are held. Now and then a read comes early or a push hits a full buffer; both
	// fail without consuming anything, so the stream stays aligned. The segment
	// ends early when a long code cannot fit behind what is already held.
	task automatic run_wellformed(int budget);
		int            stop_at;
		bit            stuck;
		logic [7:0]    b;
		planned_read_t rd;
		stop_at = items_sent + budget;
		stuck = 1'b0;
		while (!stuck && items_sent < stop_at) begin
			if (plan_reads.size() == 0)
				plan_element();
			rd = plan_reads[0];
			if (held_bits >= rd.len && (held_bits + BYTE_W > BUFFER_BITS_DEF
					|| $urandom_range(0, 99) < 55)) begin
				if (held_bits + BYTE_W > BUFFER_BITS_DEF && $urandom_range(0, 9) == 0) begin
					send_item(ACT_PUSH, 8'($urandom), 6'($urandom));
				end else begin
					send_item(rd.act, 8'($urandom), rd.wid);
					plan_reads.delete(0);
				end
			end else if (held_bits + BYTE_W <= BUFFER_BITS_DEF) begin
				if (held_bits < rd.len && $urandom_range(0, 19) == 0) begin
					send_item(rd.act, 8'($urandom), rd.wid);
				end else begin
					take_byte(b);
					send_item(ACT_PUSH, b, 6'($urandom));
				end
			end else begin
				stuck = 1'b1;
			end
		end
	endtask

	// Unstructured traffic. The share of zero bytes varies per burst so that long
	// zero runs, and with them overlong prefixes, come up regularly.
	task automatic run_noise(int budget);
		int         stop_at;
		int         zero_pct;
		logic [7:0] b;
		stop_at = items_sent + budget;
		zero_pct = $urandom_range(0, 90);
		while (items_sent < stop_at) begin
			b = ($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom);
			send_item(action_t'($urandom_range(0, 3)), b, 6'($urandom));
		end
	endtask

	// Empties the buffer with fixed-width reads so the next segment starts aligned.
	task automatic drain_buffer();
		while (held_bits > 0)
			send_item(ACT_READ_U, 8'($urandom), (held_bits >= FIELD_MAX)
					? 6'($urandom_range(FIELD_MAX, 63)) : 6'(held_bits));
		plan_bits.delete();
		plan_reads.delete();
	endtask

	// Result side: a random hold-off before every transfer, quiet stretches with
	// no hold-off at all, and one long hold-off that fills the block.
	initial begin : result_sink
		int wait_cycles;
		int taken;
		bit rx_quiet;
		taken = 0;
		rx_quiet = 1'b0;
		forever begin
			if (taken % 40 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			wait_cycles = rx_quiet ? 0 : $urandom_range(0, 14);
			if (taken == HOLD_AT) begin
				rx_holding <= 1'b1;
				wait_cycles = HOLD_CYCLES;
			end
			if (wait_cycles > 0) begin
				result_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			result_stall <= 1'b0;
			rx_holding <= 1'b0;
			do @(posedge clk); while (!(result_valid === 1'b1 && result_stall === 1'b0));
			taken++;
		end
	end

	// Every result transfer is matched against the oldest queued expectation.
	always @(posedge clk) begin : field_check
		result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_fields.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected result: value %h used %0d left %0d status %0d",
							value, bits_used, bits_left, status);
			end else begin
				want = pending_fields.pop_front();
				if (value !== want.value || bits_used !== want.bits_used
						|| bits_left !== want.bits_left || status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("result mismatch: expected value %h used %0d left %0d status %0d, %s",
								want.value, want.bits_used, want.bits_left, want.status,
								$sformatf("got value %h used %0d left %0d status %0d",
								value, bits_used, bits_left, status));
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("exp_golomb_bit_reader test failed");
			$finish;
		end
	end

	initial begin : stimulus
		int seg;
		int i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the table in order from the reset state.
		tx_quiet = 1'b0;
		for (i = 0; i < 27; i++)
			send_item(directed_rows[i].act, directed_rows[i].byt, directed_rows[i].wid,
					directed_rows[i].known, directed_rows[i].want);
		wait_for_results();

		// Random part: mostly well-formed element streams, some noise bursts, each
		// segment followed by a drain so the next one starts from an empty buffer.
		seg = 0;
		drain_buffer();
		while (items_sent < ITEM_TARGET) begin
			tx_quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) != 0)
				run_wellformed($urandom_range(20, 80));
			else
				run_noise($urandom_range(5, 30));
			drain_buffer();
			seg++;
			if (seg % 5 == 0)
				wait_for_results();
		end

		// Wait out the outstanding results, then idle to catch any stray one.
		wait_for_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_fields.size() == 0)
			$display("exp_golomb_bit_reader test passed");
		else
			$display("exp_golomb_bit_reader test failed");
		$finish;
	end

endmodule
